// File: src/indexed_insert_delete_array_assert.svh
// Assertion helpers shared by the block's modules.
// AST_IMPL: same-cycle implication. AST_NEXT: next-cycle implication.
`ifndef INDEXED_INSERT_DELETE_ARRAY_ASSERT_SVH
`define INDEXED_INSERT_DELETE_ARRAY_ASSERT_SVH

`ifndef SYNTH
`define AST_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define AST_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define AST_IMPL(lbl, clk, rst, ante, cons, msg)
`define AST_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: src/iida_pkg.sv
`timescale 1ns / 1ps

package iida_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int OPCODE_W = 3;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_GET    = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SET    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOB  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the accepted item
    logic eval;    // read the addressed entry (used by get)
    logic init;    // preset the shift pointer
    logic step;    // one shift read, write follows in the next cycle
    logic finish;  // final write, count update, load result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic shift_ins;  // valid insert that must move entries up
    logic shift_del;  // valid delete that must move entries down
    logic last;       // pointer sits on the final entry to move
  } dp_sts_t;

endpackage

// File: src/iida_datapath.sv
`timescale 1ns / 1ps
`include "indexed_insert_delete_array_assert.svh"

module iida_datapath #(
  parameter int CAPACITY = iida_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  iida_pkg::in_item_t  req,
  input  iida_pkg::dp_cmd_t   cmd,
  output iida_pkg::dp_sts_t   sts,
  output iida_pkg::out_item_t rsp
);
  import iida_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic signed [DATA_W-1:0] mem [CAPACITY];

  in_item_t                 item_q;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [AW-1:0]            ptr;
  logic [AW-1:0]            waddr_q;
  logic                     pipe_valid;
  logic signed [DATA_W-1:0] rdata;

  logic [PW-1:0]            pos_w;
  logic [PW-1:0]            cnt_w;
  logic [AW-1:0]            pos_a;
  logic [AW-1:0]            cnt_m1;
  logic                     full;
  logic [STATUS_W-1:0]      st;
  logic                     ok;
  logic                     is_ins;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  assign pos_w  = PW'(item_q.position);
  assign cnt_w  = PW'(count);
  assign pos_a  = pos_w[AW-1:0];
  assign cnt_m1 = AW'(count - CW'(1));
  assign full   = (count == CW'(CAPACITY));
  assign is_ins = (item_q.opcode == OP_INSERT);

  always_comb begin
    st = ST_OK;
    case (item_q.opcode)
      OP_APPEND: begin
        if (full) st = ST_FULL;
      end
      OP_INSERT: begin
        if (pos_w > cnt_w) st = ST_OOB;
        else if (full)     st = ST_FULL;
      end
      OP_DELETE, OP_GET, OP_SET: begin
        if (pos_w >= cnt_w) st = ST_OOB;
      end
      default: st = ST_OK;
    endcase
  end

  assign ok = (st == ST_OK);

  assign sts.shift_ins = ok && is_ins && (pos_w != cnt_w);
  assign sts.shift_del = ok && (item_q.opcode == OP_DELETE) && ((pos_w + PW'(1)) != cnt_w);
  assign sts.last      = is_ins ? (ptr == pos_a) : (ptr == cnt_m1);

  // read port: shift pointer while moving, addressed entry otherwise
  assign rd_en   = cmd.step | cmd.eval;
  assign rd_addr = cmd.step ? ptr : pos_a;

  // write port: pending shift write wins; final writes come at finish, after any drain
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_a;
    wr_data = item_q.data_in;
    if (pipe_valid) begin
      wr_en   = 1'b1;
      wr_addr = waddr_q;
      wr_data = rdata;
    end else if (cmd.finish && ok) begin
      case (item_q.opcode)
        OP_APPEND: begin
          wr_en   = 1'b1;
          wr_addr = cnt_w[AW-1:0];
        end
        OP_INSERT, OP_SET: wr_en = 1'b1;
        default:           wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_comb begin
    count_next = count;
    if (ok) begin
      case (item_q.opcode)
        OP_APPEND, OP_INSERT: count_next = count + CW'(1);
        OP_DELETE:            count_next = count - CW'(1);
        default:              count_next = count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_q <= req;
    if (cmd.init) ptr <= is_ins ? cnt_m1 : AW'(pos_w + PW'(1));
    else if (cmd.step) ptr <= is_ins ? (ptr - AW'(1)) : (ptr + AW'(1));
    if (cmd.step) waddr_q <= is_ins ? (ptr + AW'(1)) : (ptr - AW'(1));
    if (cmd.finish) begin
      rsp.read_value <= (ok && (item_q.opcode == OP_GET)) ? rdata : '0;
      rsp.status     <= st;
      rsp.count      <= COUNT_W'(count_next);
      rsp.is_empty   <= (count_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= cmd.step;
      if (cmd.finish) count <= count_next;
    end
  end

  `AST_IMPL(a_count_cap, clk, rst, 1'b1, count <= CW'(CAPACITY), "count above capacity")
  `AST_NEXT(a_append_grows, clk, rst, cmd.finish && ok && (item_q.opcode == OP_APPEND), count == $past(count) + CW'(1), "append did not grow count")
  `AST_IMPL(a_pipe_from_step, clk, rst, pipe_valid, $past(cmd.step), "shift write without shift read")

endmodule

// File: src/iida_ctrl.sv
`timescale 1ns / 1ps
`include "indexed_insert_delete_array_assert.svh"

module iida_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  input  iida_pkg::dp_sts_t sts,
  output iida_pkg::dp_cmd_t cmd
);
  import iida_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EVAL  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.shift_ins || sts.shift_del) begin
          cmd.init   = 1'b1;
          state_next = S_SHIFT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        cmd.step = 1'b1;
        if (sts.last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!(rsp_valid && rsp_stall)) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign req_stall      = (state != S_IDLE);
  assign rsp_valid_next = cmd.finish | (rsp_valid & rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  `AST_NEXT(a_finish_shows, clk, rst, cmd.finish, rsp_valid, "result not presented after finish")
  `AST_IMPL(a_eval_after_accept, clk, rst, state == S_EVAL, $past(state == S_IDLE && req_valid), "eval without accepted item")
  `AST_IMPL(a_drain_after_last, clk, rst, state == S_DRAIN, $past(state == S_SHIFT && sts.last), "drain without final shift")

endmodule

// File: src/indexed_insert_delete_array.sv
`timescale 1ns / 1ps
// channel   dir  handshake            payload
// req       in   req_valid/req_stall  in_item_t  {opcode, position, data_in}
// rsp       out  rsp_valid/rsp_stall  out_item_t {read_value, status, count, is_empty}
//
// No entry moved (append, get, set, rejected or unknown op, insert at the end,
// delete of the last entry): accept, eval, done. Otherwise a shift loop moves up
// to CAPACITY - 1 entries, one per cycle, through the element memory, then a drain.
// rst (sync, active high) clears the count and handshake state; no clearing pass.
// One result register: a new item is taken while a result waits, and a finished
// item holds in the done state until rsp is free.

module indexed_insert_delete_array #(
  parameter int CAPACITY = iida_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  iida_pkg::in_item_t  req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output iida_pkg::out_item_t rsp
);
  import iida_pkg::*;

  dp_cmd_t cmd;  // sequencing commands
  dp_sts_t sts;  // decode and shift-end flags

  // Controller: accept, classify, shift loop, result handoff.
  iida_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: item register, count, element memory, shift pointer, result.
  iida_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

// File: sim/indexed_insert_delete_array_checker.sv
`timescale 1ns / 1ps

module indexed_insert_delete_array_checker #(
  parameter int CAPACITY = iida_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_stall,
  input  iida_pkg::in_item_t  req,
  input  logic                rsp_valid,
  input  logic                rsp_stall,
  input  iida_pkg::out_item_t rsp,
  output int                  failures,
  output int                  pending_results,
  output int                  array_level
);
  import iida_pkg::*;

  logic signed [DATA_W-1:0] shadow_words [CAPACITY];
  int                       shadow_len;
  out_item_t                expected_results [$];
  int                       fail_tally;

  assign failures = fail_tally;

  initial begin
    fail_tally      = 0;
    shadow_len      = 0;
    pending_results = 0;
    array_level     = 0;
  end

  // Applies one operation to the shadow array and returns the result it owes.
  function automatic out_item_t apply_array_op(in_item_t it);
    out_item_t res;
    res        = '0;
    res.status = ST_OK;
    case (it.opcode)
      OP_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          shadow_words[shadow_len] = it.data_in;
          shadow_len++;
        end
      end
      OP_INSERT: begin
        // bounds test wins over the full test
        if (int'(it.position) > shadow_len) begin
          res.status = ST_OOB;
        end else if (shadow_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (int k = shadow_len; k > int'(it.position); k--)
            shadow_words[k] = shadow_words[k-1];
          shadow_words[it.position] = it.data_in;
          shadow_len++;
        end
      end
      OP_DELETE: begin
        if (int'(it.position) >= shadow_len) begin
          res.status = ST_OOB;
        end else begin
          for (int k = int'(it.position); k + 1 < shadow_len; k++)
            shadow_words[k] = shadow_words[k+1];
          shadow_len--;
        end
      end
      OP_GET: begin
        if (int'(it.position) >= shadow_len) res.status = ST_OOB;
        else res.read_value = shadow_words[it.position];
      end
      OP_SET: begin
        if (int'(it.position) >= shadow_len) res.status = ST_OOB;
        else shadow_words[it.position] = it.data_in;
      end
      default: ;  // spare opcodes: no effect, status ok
    endcase
    res.count    = COUNT_W'(shadow_len);
    res.is_empty = (shadow_len == 0);
    return res;
  endfunction

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      fail_tally++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      shadow_len = 0;
      expected_results.delete();
    end else begin
      // retire the oldest expectation before queuing a new one
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %0h", $time, rsp);
          fail_tally++;
        end else begin
          want = expected_results.pop_front();
          compare_field("read_value", want.read_value, rsp.read_value);
          compare_field("status", 32'(want.status), 32'(rsp.status));
          compare_field("count", 32'(want.count), 32'(rsp.count));
          compare_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
        end
      end
      if (req_valid && !req_stall)
        expected_results.push_back(apply_array_op(req));
    end
    pending_results <= expected_results.size();
    array_level     <= shadow_len;
  end

endmodule

// File: sim/indexed_insert_delete_array_tb.sv
`timescale 1ns / 1ps

module indexed_insert_delete_array_tb;
  import iida_pkg::*;

  // spare opcode range, answered with status ok and no change
  localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;

  localparam int ITEMS_PER_MIX = 119;
  localparam int LONG_HOLD     = 300;   // receiver hold-off, in cycles

  // operation mix of a random stretch
  typedef enum {MIX_GROW, MIX_CHURN, MIX_SHRINK} mix_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  in_item_t  req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  out_item_t rsp;

  int failures;
  int pending_results;
  int array_level;

  // idle odds in percent, per phase; set by the stimulus process
  int send_pct      = 0;
  int recv_pct      = 0;
  int hold_requests = 0;
  int holds_served  = 0;

  int send_pct_plan [4] = '{0, 73, 0, 13};
  int recv_pct_plan [4] = '{0, 0, 73, 13};

  always #5 clk = ~clk;

  indexed_insert_delete_array u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  indexed_insert_delete_array_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .req             (req),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .rsp             (rsp),
    .failures        (failures),
    .pending_results (pending_results),
    .array_level     (array_level)
  );

  // Offers one item, with a random gap first, and returns at the edge where
  // it is taken. Valid stays high into the next call unless a gap is drawn,
  // so valid is never lowered and raised in the same step.
  task automatic send_item(input in_item_t it);
    if (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_pct);
    end
    req_valid <= 1'b1;
    req       <= it;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic send_op(input logic [OPCODE_W-1:0] op, input int pos, input logic [31:0] val);
    in_item_t it;
    it.opcode   = op;
    it.position = POS_W'(pos);
    it.data_in  = val;
    send_item(it);
  endtask

  // Drops valid and waits until every item sent so far has been answered.
  task automatic drain_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // Random operation. The mix steers the fill level; positions mostly hit the
  // live range (the level lags a few items, so some land just outside), and
  // a share spans the whole 7-bit field.
  function automatic in_item_t pick_array_op(mix_t mix, int lvl);
    in_item_t it;
    int       roll;
    roll       = $urandom_range(0, 99);
    it.data_in = $urandom;
    case (mix)
      MIX_GROW:
        it.opcode = (roll < 45) ? OP_APPEND : (roll < 80) ? OP_INSERT :
                    (roll < 86) ? OP_DELETE : (roll < 92) ? OP_GET :
                    (roll < 98) ? OP_SET : OP_SPARE_FIRST;
      MIX_SHRINK:
        it.opcode = (roll < 6) ? OP_APPEND : (roll < 12) ? OP_INSERT :
                    (roll < 74) ? OP_DELETE : (roll < 86) ? OP_GET :
                    (roll < 98) ? OP_SET : OP_SPARE_FIRST;
      default:
        it.opcode = (roll < 15) ? OP_APPEND : (roll < 35) ? OP_INSERT :
                    (roll < 60) ? OP_DELETE : (roll < 78) ? OP_GET :
                    (roll < 96) ? OP_SET : OP_SPARE_FIRST;
    endcase
    if (it.opcode == OP_SPARE_FIRST)
      it.opcode = OPCODE_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    if ($urandom_range(0, 99) < 15)
      it.position = POS_W'($urandom_range(0, 127));
    else if (it.opcode == OP_INSERT)
      it.position = POS_W'($urandom_range(0, lvl));
    else
      it.position = POS_W'((lvl > 0) ? $urandom_range(0, lvl - 1) : 0);
    return it;
  endfunction

  // Receiver: random stall per cycle, plus a long hold-off on request while
  // the sender keeps offering, so the block fills and stalls its input.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      rsp_stall <= (recv_pct != 0) && ($urandom_range(0, 99) < recv_pct);
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    mix_t mix;
    do @(posedge clk); while (rst);

    // Directed: empty-array rejections, field extremes, shifts at both ends
    // and in the middle, spare opcodes, far-out positions.
    send_op(OP_GET, 0, 32'h0);                 // get on empty
    send_op(OP_DELETE, 0, 32'h0);              // delete on empty
    send_op(OP_SET, 0, 32'h1234_5678);         // set on empty
    send_op(OP_INSERT, 1, 32'h1);              // insert past the end
    send_op(OP_INSERT, 0, 32'h7FFF_FFFF);      // insert at the end acts as append
    send_op(OP_APPEND, 127, 32'h8000_0000);    // position ignored by append
    send_op(OP_APPEND, 0, 32'h0);
    send_op(OP_INSERT, 1, 32'hFFFF_FFFF);      // middle, shifts up
    send_op(OP_INSERT, 0, 32'h5555_5555);      // front, shifts all
    send_op(OP_GET, 4, 32'h0);                 // last entry
    send_op(OP_GET, 5, 32'h0);                 // one past the end
    send_op(OP_SET, 2, 32'hAAAA_AAAA);
    send_op(OP_GET, 2, 32'h0);
    send_op(OP_DELETE, 4, 32'h0);              // last, nothing moves
    send_op(OP_DELETE, 0, 32'h0);              // front, shifts all down
    send_op(OP_DELETE, 1, 32'h0);              // middle
    send_op(OP_SPARE_FIRST, 127, 32'hFFFF_FFFF);
    send_op(OP_SPARE_FIRST + 3'd1, 64, 32'h8000_0000);
    send_op(OP_SPARE_LAST, 0, 32'h7FFF_FFFF);
    send_op(OP_GET, 127, 32'h0);
    send_op(OP_INSERT, 127, 32'h0);
    send_op(OP_DELETE, 64, 32'h0);
    send_op(OP_SET, 127, 32'hFFFF_FFFF);
    send_op(OP_GET, 0, 32'h0);
    drain_results();

    // Random: each idle setting runs grow, churn and shrink stretches so the
    // array passes through full and back toward empty.
    for (int ph = 0; ph < 4; ph++) begin
      send_pct = send_pct_plan[ph];
      recv_pct = recv_pct_plan[ph];
      for (int m = 0; m < 3; m++) begin
        mix = (m == 0) ? MIX_GROW : (m == 1) ? MIX_CHURN : MIX_SHRINK;
        for (int n = 0; n < ITEMS_PER_MIX; n++) begin
          if (mix == MIX_GROW && n == 40 && (ph == 0 || ph == 2))
            hold_requests++;
          send_item(pick_array_op(mix, array_level));
        end
      end
      // sender pause until the block has answered everything
      drain_results();
    end

    repeat (CAPACITY_DEF + 8) @(posedge clk);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
